>>> rtl/mru16_pkg.sv
// mru16_pkg: types, constants and unpack functions for the raw unpacker
// no dependencies; imported by mipi_raw_unpack_to_16
package mru16_pkg;

  typedef enum logic [1:0] {
    MODE_RAW8  = 2'd0,
    MODE_RAW10 = 2'd1,
    MODE_RAW12 = 2'd2,
    MODE_RAW14 = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [1:0] REG_BIT_DEPTH_MODE     = 2'd0;
  localparam logic [1:0] REG_LINE_WIDTH_PIXELS  = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT_LINES = 2'd2;
  localparam logic [1:0] REG_ALIGNMENT_BYTES    = 2'd3;

  localparam int MAX_WIDTH  = 8192;
  localparam int LINE_W     = 15;   // byte position, payload and stride
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DIV,
    ST_FINISH,
    ST_RUN
  } calc_state_t;

  typedef struct packed {
    logic [13:0] pixel;
    logic        eol;
    logic        eof;
    logic        last;
  } pix_entry_t;

  function automatic logic [2:0] grp_bytes(mode_t mode);
    logic [2:0] n;
    case (mode)
      MODE_RAW8:  n = 3'd1;
      MODE_RAW10: n = 3'd5;
      MODE_RAW12: n = 3'd3;
      MODE_RAW14: n = 3'd7;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] grp_pix(mode_t mode);
    logic [2:0] n;
    case (mode)
      MODE_RAW8:  n = 3'd1;
      MODE_RAW10: n = 3'd4;
      MODE_RAW12: n = 3'd2;
      MODE_RAW14: n = 3'd4;
      default:    n = 3'd1;
    endcase
    return n;
  endfunction

  // b holds the full group, first byte in b[0]
  function automatic logic [3:0][13:0] unpack_group(mode_t mode, logic [6:0][7:0] b);
    logic [3:0][13:0] px;
    logic [23:0]      lsb;
    px  = '0;
    lsb = {b[6], b[5], b[4]};
    case (mode)
      MODE_RAW8: begin
        px[0] = {6'd0, b[0]};
      end
      MODE_RAW10: begin
        for (int i = 0; i < 4; i++) px[i] = {4'd0, b[i], b[4][2*i +: 2]};
      end
      MODE_RAW12: begin
        px[0] = {2'd0, b[0], b[2][3:0]};
        px[1] = {2'd0, b[1], b[2][7:4]};
      end
      MODE_RAW14: begin
        for (int i = 0; i < 4; i++) px[i] = {b[i], lsb[6*i +: 6]};
      end
      default: px = '0;
    endcase
    return px;
  endfunction

endpackage

>>> rtl/mipi_raw_unpack_to_16.sv
// mipi_raw_unpack_to_16: packed RAW8/10/12/14 byte stream to one pixel per word
// depends on mru16_pkg
//
// Usage:
//   Input channel (in_valid/in_ready/data_byte) takes one packed byte per word.
//   Output channel (out_valid/out_ready) gives one pixel per word with
//   end_of_line, end_of_frame and last_of_run marks. Bytes past the line
//   payload up to the alignment stride are padding and give no pixels.
//   Configuration is a plain write port (cfg_we/cfg_index/cfg_wdata); write it
//   only while no byte is in flight.
// Timing:
//   One byte accepted per cycle while in_ready is high. The pixels of a
//   group enter an 8-entry queue at the edge that takes its last byte, so
//   out_valid is high in the next cycle. The output drains one pixel per
//   cycle while out_ready is high; in_ready drops while fewer than four
//   queue entries are free, which is what throttles the input when the
//   receiver stalls.
//   After reset and after every configuration write the line stride is
//   recomputed by a bit-serial remainder unit with in_ready low (one load,
//   fifteen divide steps, one finish).
// Reset: synchronous; registers return to their defaults (RAW8, 1920 pixels,
//   1080 lines, no padding), the queue empties and the line/frame counters clear.
module mipi_raw_unpack_to_16
  import mru16_pkg::*;
#(
  parameter int MAX_HEIGHT = 8192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] pixel_value,
  output logic        end_of_line,
  output logic        end_of_frame,
  output logic        last_of_run
);

  localparam int LCW = $clog2(MAX_HEIGHT);

  // configuration
  mode_t       mode;
  logic [13:0] line_width_pixels;
  logic [13:0] frame_height_lines;
  logic [8:0]  alignment_bytes;

  // stride calculation
  calc_state_t state, state_next;
  logic [LINE_W-1:0] payload;
  logic [LINE_W-1:0] payload_calc;
  logic [LINE_W-1:0] stride;
  logic [8:0]        rem;
  logic [9:0]        rem_shift;
  logic [3:0]        bit_idx;
  logic [13:0]       width_sat;
  logic [LINE_W-1:0] groups;

  // line state
  logic [5:0][7:0]   group_bytes, group_bytes_next;
  logic [2:0]        group_position, group_position_next;
  logic [LINE_W-1:0] line_byte_count, line_byte_count_next;
  logic [LCW-1:0]    line_count, line_count_next;

  // per-byte datapath
  logic              accept;
  logic [2:0]        gbytes, npix;
  logic [6:0][7:0]   full;
  logic [3:0][13:0]  px;
  logic [LINE_W:0]   pos_inc;
  logic              in_payload, last_in_line, group_done, eof_hit;
  logic [15:0]       height_eff, line_inc;
  logic [2:0]        push_n;
  pix_entry_t [3:0]  push_data;

  // output queue
  pix_entry_t        fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               pop;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_RAW8;
      line_width_pixels  <= 14'd1920;
      frame_height_lines <= 14'd1080;
      alignment_bytes    <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BIT_DEPTH_MODE:     mode <= mode_t'(cfg_wdata[1:0]);
        REG_LINE_WIDTH_PIXELS:  line_width_pixels <= cfg_wdata;
        REG_FRAME_HEIGHT_LINES: frame_height_lines <= cfg_wdata;
        REG_ALIGNMENT_BYTES:    alignment_bytes <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // ---------------- payload and stride ----------------
  always_comb begin
    width_sat = (line_width_pixels > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : line_width_pixels;
    case (mode)
      MODE_RAW8:  groups = {1'b0, width_sat};
      MODE_RAW12: groups = {2'b0, width_sat[13:1]};
      default:    groups = {3'b0, width_sat[13:2]};
    endcase
    case (mode)
      MODE_RAW8:  payload_calc = groups;
      MODE_RAW10: payload_calc = groups + (groups << 2);
      MODE_RAW12: payload_calc = groups + (groups << 1);
      MODE_RAW14: payload_calc = (groups << 3) - groups;
      default:    payload_calc = groups;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:   state_next = ST_DIV;
      ST_DIV:    if (bit_idx == 4'd0) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_RUN;
      ST_RUN:    state_next = ST_RUN;
      default:   state_next = ST_LOAD;
    endcase
    if (cfg_we) state_next = ST_LOAD;
  end

  // one remainder bit per cycle, payload mod alignment
  assign rem_shift = {rem, payload[bit_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      payload <= '0;
      stride  <= '0;
      rem     <= '0;
      bit_idx <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          payload <= payload_calc;
          rem     <= '0;
          bit_idx <= 4'(LINE_W - 1);
        end
        ST_DIV: begin
          if (rem_shift >= {1'b0, alignment_bytes}) rem <= 9'(rem_shift - {1'b0, alignment_bytes});
          else                                      rem <= rem_shift[8:0];
          bit_idx <= bit_idx - 4'd1;
        end
        ST_FINISH: begin
          if (alignment_bytes == 9'd0 || rem == 9'd0) stride <= payload;
          else stride <= payload + LINE_W'(alignment_bytes) - LINE_W'(rem);
        end
        default: ;
      endcase
    end
  end

  // ---------------- per-byte unpack ----------------
  assign in_ready = (state == ST_RUN) && (count <= (FIFO_AW+1)'(FIFO_DEPTH - 4));
  assign accept   = in_valid && in_ready;

  always_comb begin
    gbytes = grp_bytes(mode);
    npix   = grp_pix(mode);
    for (int i = 0; i < 6; i++) full[i] = group_bytes[i];
    full[6] = 8'd0;
    full[3'(gbytes - 3'd1)] = data_byte;
    px = unpack_group(mode, full);

    pos_inc      = {1'b0, line_byte_count} + (LINE_W+1)'(1);
    in_payload   = line_byte_count < payload;
    last_in_line = pos_inc == {1'b0, payload};
    group_done   = ({1'b0, group_position} + 4'd1) >= {1'b0, gbytes};

    height_eff = {2'b0, frame_height_lines};
    if (height_eff > 16'(MAX_HEIGHT)) height_eff = 16'(MAX_HEIGHT);
    if (height_eff == 16'd0)          height_eff = 16'd1;
    line_inc = 16'(line_count) + 16'd1;
    eof_hit  = line_inc >= height_eff;

    for (int k = 0; k < 4; k++) begin
      push_data[k].pixel = px[k];
      push_data[k].last  = (3'(k + 1) == npix);
      push_data[k].eol   = push_data[k].last && last_in_line;
      push_data[k].eof   = push_data[k].eol && eof_hit;
    end

    group_bytes_next     = group_bytes;
    group_position_next  = group_position;
    line_byte_count_next = line_byte_count;
    line_count_next      = line_count;
    push_n               = 3'd0;

    // an empty payload drops the byte with no state change
    if (accept && payload != '0) begin
      if (in_payload) begin
        if (group_done) begin
          push_n              = npix;
          group_position_next = 3'd0;
          if (last_in_line) line_count_next = eof_hit ? '0 : LCW'(line_inc);
        end else begin
          if (group_position < 3'd6) group_bytes_next[group_position] = data_byte;
          group_position_next = last_in_line ? 3'd0 : group_position + 3'd1;
        end
      end
      if (pos_inc >= {1'b0, stride}) begin
        line_byte_count_next = '0;
        group_position_next  = 3'd0;
      end else begin
        line_byte_count_next = pos_inc[LINE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bytes     <= '0;
      group_position  <= '0;
      line_byte_count <= '0;
      line_count      <= '0;
    end else begin
      group_bytes     <= group_bytes_next;
      group_position  <= group_position_next;
      line_byte_count <= line_byte_count_next;
      line_count      <= line_count_next;
    end
  end

  // ---------------- output queue ----------------
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < push_n) fifo[wr_ptr + FIFO_AW'(k)] <= push_data[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) rd_ptr <= rd_ptr + FIFO_AW'(1);
      count <= count + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  assign pixel_value  = fifo[rd_ptr].pixel;
  assign end_of_line  = fifo[rd_ptr].eol;
  assign end_of_frame = fifo[rd_ptr].eof;
  assign last_of_run  = fifo[rd_ptr].last;

  // ---------------- assertions ----------------
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("pixel queue overflow");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("input taken while stride recomputes");

  a_stride_covers_payload: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (stride >= payload))
    else $error("stride shorter than payload");

  a_eof_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_frame) |-> (end_of_line && last_of_run))
    else $error("end of frame without end of line");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for the raw byte unpacker, directed table then random line phases
// depends on mru16_pkg and mipi_raw_unpack_to_16; pixels are checked against an in-bench model
`timescale 1ns / 1ps

module tb_top;
  import mru16_pkg::*;

  localparam int HEIGHT_CAP    = 8192;
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_ITEMS   = 210;
  localparam logic [1:0] NO_REG = 2'd0;

  typedef enum logic {
    ROW_WRITE = 1'b0,
    ROW_BYTE  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [13:0] value;
    logic        typed;
    logic [13:0] px;
    logic        eol;
    logic        eof;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = NO_REG;
  logic [13:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] pixel_value;
  logic        end_of_line;
  logic        end_of_frame;
  logic        last_of_run;

  // register copies and line state of the bench model
  mode_t       cfg_mode = MODE_RAW8;
  logic [13:0] cfg_width = 14'd1920;
  logic [13:0] cfg_height = 14'd1080;
  logic [8:0]  cfg_align = '0;
  logic [7:0]  held_bytes [6] = '{default: 8'd0};
  logic [2:0]  held_count = '0;
  logic [14:0] line_pos = '0;
  int          line_idx = 0;

  pix_entry_t  pix_expect_q [$];
  bit          failed = 1'b0;
  bit          no_gaps = 1'b0;
  int          sent_items = 0;
  stim_row_t   dir_rows [37];

  mipi_raw_unpack_to_16 u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_value  (pixel_value),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  function automatic void line_geometry(output int gb, output int gp, output int payload,
                                        output int stride);
    int w;
    int a;
    case (cfg_mode)
      MODE_RAW8: begin
        gb = 1; gp = 1;
      end
      MODE_RAW10: begin
        gb = 5; gp = 4;
      end
      MODE_RAW12: begin
        gb = 3; gp = 2;
      end
      default: begin
        gb = 7; gp = 4;
      end
    endcase
    w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
    a = int'(cfg_align);
    payload = (w / gp) * gb;
    stride = payload;
    if (a != 0 && payload % a != 0)
      stride = payload + a - payload % a;
  endfunction

  // queues the pixels one byte produces; returns 1 when the byte lands in the payload
  function automatic bit predict_pixels(input logic [7:0] b);
    int gb, gp, payload, stride, pos, h, n, i, lsb;
    int g [7];
    int px [4];
    bit last_in_line, eof;
    pix_entry_t e;
    line_geometry(gb, gp, payload, stride);
    // width below one group: byte is dropped, nothing moves
    if (payload == 0) return 1'b0;
    h = (cfg_height > HEIGHT_CAP) ? HEIGHT_CAP : int'(cfg_height);
    if (h == 0) h = 1;
    pos = int'(line_pos);
    eof = 1'b0;
    if (pos < payload) begin
      last_in_line = (pos + 1 == payload);
      if (held_count + 1 >= gb) begin
        for (i = 0; i < 6; i++) g[i] = int'(held_bytes[i]);
        g[6] = 0;
        g[gb - 1] = int'(b);
        case (cfg_mode)
          MODE_RAW8: begin
            px[0] = g[0];
            n = 1;
          end
          MODE_RAW10: begin
            for (i = 0; i < 4; i++) px[i] = (g[i] << 2) | ((g[4] >> (2 * i)) & 'h3);
            n = 4;
          end
          MODE_RAW12: begin
            px[0] = (g[0] << 4) | (g[2] & 'hF);
            px[1] = (g[1] << 4) | (g[2] >> 4);
            n = 2;
          end
          default: begin
            lsb = g[4] | (g[5] << 8) | (g[6] << 16);
            for (i = 0; i < 4; i++) px[i] = (g[i] << 6) | ((lsb >> (6 * i)) & 'h3F);
            n = 4;
          end
        endcase
        held_count = '0;
        if (last_in_line) begin
          eof = (line_idx + 1 >= h);
          line_idx = eof ? 0 : line_idx + 1;
        end
        for (i = 0; i < n; i++) begin
          e.pixel = 14'(px[i]);
          e.last  = (i == n - 1);
          e.eol   = e.last && last_in_line;
          e.eof   = e.eol && eof;
          pix_expect_q.push_back(e);
        end
      end else begin
        if (held_count < 6) held_bytes[held_count] = b;
        held_count = held_count + 3'd1;
        if (last_in_line) held_count = '0;
      end
    end
    if (pos + 1 >= stride) begin
      line_pos = '0;
      held_count = '0;
    end else begin
      line_pos = 15'(pos + 1);
    end
    return pos < payload;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BIT_DEPTH_MODE:     cfg_mode = mode_t'(val[1:0]);
      REG_LINE_WIDTH_PIXELS:  cfg_width = val;
      REG_FRAME_HEIGHT_LINES: cfg_height = val;
      REG_ALIGNMENT_BYTES:    cfg_align = val[8:0];
      default: ;
    endcase
  endtask

  // returns at the edge that took the word, valid still high
  task automatic push_byte(input logic [7:0] b, input bit typed, input pix_entry_t typed_px);
    int held;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 6) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    held = pix_expect_q.size();
    void'(predict_pixels(b));
    sent_items++;
    // hand-written rows replace what the model queued for this word
    if (typed) begin
      while (pix_expect_q.size() > held) pix_expect_q.delete(pix_expect_q.size() - 1);
      pix_expect_q.push_back(typed_px);
    end
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pix_expect_q.size() != 0) @(posedge clk);
    // partial groups and padding leave nothing to wait on, so give the pipe time
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase();
    int gb, gp, payload, stride, sel, nbytes, k;
    mode_t m;
    m = mode_t'(2'($urandom_range(0, 3)));
    drain_and_settle();
    write_reg(REG_BIT_DEPTH_MODE, {12'd0, m});
    line_geometry(gb, gp, payload, stride);
    sel = $urandom_range(0, 99);
    if (sel < 5)
      write_reg(REG_LINE_WIDTH_PIXELS, 14'h3FFF);
    else if (sel < 10)
      write_reg(REG_LINE_WIDTH_PIXELS, 14'd8192);
    else if (sel < 16 && gp > 1)
      write_reg(REG_LINE_WIDTH_PIXELS, 14'($urandom_range(1, gp - 1)));
    else if (sel < 30)
      write_reg(REG_LINE_WIDTH_PIXELS,
                14'(gp * $urandom_range(1, 4) + $urandom_range(0, gp - 1)));
    else
      write_reg(REG_LINE_WIDTH_PIXELS, 14'(gp * $urandom_range(1, 4)));
    sel = $urandom_range(0, 99);
    if (sel < 5)
      write_reg(REG_FRAME_HEIGHT_LINES, 14'h3FFF);
    else if (sel < 10)
      write_reg(REG_FRAME_HEIGHT_LINES, 14'd8192);
    else
      write_reg(REG_FRAME_HEIGHT_LINES, 14'($urandom_range(0, 3)));
    sel = $urandom_range(0, 99);
    if (sel < 40)
      write_reg(REG_ALIGNMENT_BYTES, 14'd0);
    else if (sel < 92)
      write_reg(REG_ALIGNMENT_BYTES, 14'($urandom_range(1, 16)));
    else
      write_reg(REG_ALIGNMENT_BYTES, 14'd256);
    line_geometry(gb, gp, payload, stride);
    if (payload == 0)
      nbytes = $urandom_range(1, 6);
    else if (payload > 64)
      nbytes = $urandom_range(4, 24);
    else if ($urandom_range(0, 99) < 15)
      nbytes = $urandom_range(1, stride + payload);
    else if (stride > 64)
      nbytes = stride;
    else
      nbytes = stride * $urandom_range(1, 3);
    // keep the whole run near the item budget
    if (nbytes > TOTAL_ITEMS - sent_items) nbytes = TOTAL_ITEMS - sent_items;
    for (k = 0; k < nbytes; k++) push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  always @(posedge clk) begin : pixel_check
    pix_entry_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pix_expect_q.size() == 0) begin
          $error("pixel_value: no word expected, got %0d", pixel_value);
          failed = 1'b1;
        end else begin
          want = pix_expect_q.pop_front();
          if (pixel_value !== want.pixel) begin
            $error("pixel_value: expected %0d, got %0d", want.pixel, pixel_value);
            failed = 1'b1;
          end
          if (end_of_line !== want.eol) begin
            $error("end_of_line: expected %0d, got %0d", want.eol, end_of_line);
            failed = 1'b1;
          end
          if (end_of_frame !== want.eof) begin
            $error("end_of_frame: expected %0d, got %0d", want.eof, end_of_frame);
            failed = 1'b1;
          end
          if (last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
            failed = 1'b1;
          end
        end
      end
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 6);
    end
  end

  initial begin
    int r;
    stim_row_t row;
    pix_entry_t typed_px;
    dir_rows = '{
      // raw8 after reset: pixel is the byte
      {ROW_BYTE,  NO_REG, 14'h00, 1'b1, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hFF, 1'b1, 14'd255, 1'b0, 1'b0},
      // shrink the line mid stride: next word only closes the line
      {ROW_WRITE, REG_LINE_WIDTH_PIXELS, 14'd2, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_FRAME_HEIGHT_LINES, 14'd2, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h5A, 1'b0, 14'd0, 1'b0, 1'b0},
      // two lines of two, frame wraps
      {ROW_BYTE,  NO_REG, 14'h01, 1'b1, 14'd1, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h02, 1'b1, 14'd2, 1'b1, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h03, 1'b1, 14'd3, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h04, 1'b1, 14'd4, 1'b1, 1'b1},
      // raw10 group plus one padding word
      {ROW_WRITE, REG_BIT_DEPTH_MODE, {12'd0, MODE_RAW10}, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_LINE_WIDTH_PIXELS, 14'd4, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_ALIGNMENT_BYTES, 14'd6, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h12, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h34, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h56, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h78, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hE4, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hAA, 1'b0, 14'd0, 1'b0, 1'b0},
      // raw12, payload already aligned so no padding
      {ROW_WRITE, REG_BIT_DEPTH_MODE, {12'd0, MODE_RAW12}, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_LINE_WIDTH_PIXELS, 14'd2, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_ALIGNMENT_BYTES, 14'd3, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hAB, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hCD, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hEF, 1'b0, 14'd0, 1'b0, 1'b0},
      // raw14, zero height acts as one line, alignment of 256 bytes
      {ROW_WRITE, REG_BIT_DEPTH_MODE, {12'd0, MODE_RAW14}, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_LINE_WIDTH_PIXELS, 14'd4, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_FRAME_HEIGHT_LINES, 14'd0, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_WRITE, REG_ALIGNMENT_BYTES, 14'd256, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hFF, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h00, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hFF, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h00, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hA5, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h5A, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'hC3, 1'b0, 14'd0, 1'b0, 1'b0},
      // width below one group: word dropped
      {ROW_WRITE, REG_LINE_WIDTH_PIXELS, 14'd3, 1'b0, 14'd0, 1'b0, 1'b0},
      {ROW_BYTE,  NO_REG, 14'h99, 1'b0, 14'd0, 1'b0, 1'b0}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (r = 0; r < $size(dir_rows); r++) begin
      row = dir_rows[r];
      if (row.kind == ROW_WRITE) begin
        drain_and_settle();
        write_reg(row.reg_idx, row.value);
      end else begin
        typed_px = {row.px, row.eol, row.eof, 1'b1};
        push_byte(row.value[7:0], row.typed, typed_px);
      end
    end
    while (sent_items < TOTAL_ITEMS) begin
      // a long stretch in the middle runs with both sides never idling
      no_gaps = (sent_items >= 70 && sent_items < 140);
      random_phase();
    end
    no_gaps = 1'b0;
    drain_and_settle();
    if (!failed)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
rtl/mru16_pkg.sv
rtl/mipi_raw_unpack_to_16.sv
tb/tb_top.sv
